>>> hdl/mssm_pkg.sv
// Shared constants, types and codes for the motor speed set and measure unit.
package mssm_pkg;

    // Potentiometer converter and pulse counter sizes.
    localparam int ADC_BITS = 12;
    localparam int ADC_FULL = (1 << ADC_BITS) - 1;
    localparam int TALLY_W  = 32;

    // Configuration port.
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DUTY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PPR      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_RPM = 3'd4;

    // Register reset values.
    localparam logic [15:0] MIN_DUTY_RESET = 16'd9830;
    localparam logic [15:0] PERIOD_RESET   = 16'd1599;
    localparam logic [23:0] WINDOW_RESET   = 24'd1000000;
    localparam logic [7:0]  PPR_RESET      = 8'd1;
    localparam logic [15:0] FULL_RPM_RESET = 16'd5000;
    localparam logic [ADC_BITS-1:0] LEVEL_RESET = ADC_BITS'(2048);

    // Q1.16 unity and microseconds per minute.
    localparam logic [16:0] ONE_Q16    = 17'h10000;
    localparam int          MUL_W      = 26;
    localparam logic [MUL_W-1:0] US_PER_MIN = 26'd60000000;

    // Serial divider sizes. Setpoint dividends are PROD_W bits wide and
    // are left aligned in the numerator shift register.
    localparam int SPAN_W = ADC_BITS + 17;
    localparam int PROD_W = SPAN_W + 1;
    localparam int NUM_W  = TALLY_W + MUL_W;
    localparam int DEN_W  = 32;
    localparam int STEP_W = 6;
    localparam logic [STEP_W-1:0] SAMPLE_STEPS = STEP_W'(PROD_W);
    localparam logic [STEP_W-1:0] TICK_STEPS   = STEP_W'(NUM_W);

    // Event codes.
    typedef enum logic [1:0] {
        FUNC_SAMPLE = 2'd0,
        FUNC_PULSE  = 2'd1,
        FUNC_TICK   = 2'd2,
        FUNC_NONE   = 2'd3
    } t_func;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DUTY_MUL,
        ST_DUTY_START,
        ST_DUTY_WAIT,
        ST_CMP_MUL,
        ST_CMP_CLAMP,
        ST_EXP_START,
        ST_EXP_WAIT,
        ST_TICK_DEN,
        ST_TICK_MUL,
        ST_TICK_START,
        ST_TICK_WAIT,
        ST_WRITE
    } t_state;

    // Request to the serial divider.
    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
        logic [NUM_W-1:0]  num;
        logic [DEN_W-1:0]  den;
    } t_div_req;

endpackage

>>> hdl/mssm_sdiv.sv
// Restoring divider that produces one quotient bit per clock cycle.
module mssm_sdiv import mssm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [NUM_W-1:0]  r_num;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W-1:0]  r_rem;
    logic [NUM_W-1:0]  r_quo;

    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           fits;

    // One trial subtraction of the divisor from the shifted remainder.
    always_comb begin
        trial = {r_rem, r_num[NUM_W-1]};
        diff  = trial - {1'b0, r_den};
        fits  = (trial >= {1'b0, r_den});
    end

    // Step counter and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift the dividend in and the quotient bits out.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_rem <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

>>> hdl/motor_speed_set_and_measure_unit.sv
// Top level of the motor speed set and measure unit: setpoint, PWM and tachometer.
//
// Each input word carries one event in i_func: a potentiometer sample, an
// encoder pulse or a microsecond tick. Every accepted word produces exactly
// one output word holding the current PWM compare value, the expected speed,
// the last measured speed and a flag that is set when the word closed a
// measurement window. A word is taken when valid is high and stall is low.
// The block works on one word at a time and holds o_in_stall high until it
// has handed the result to its output register:
//   pulse, tick inside a window, unused code: straight to the write state;
//   sample: two 30-step passes of the bit-serial divider (duty scaling
//   and expected speed) plus one multiply each;
//   tick that closes a window: a 26-step shift-and-add multiply by
//   60,000,000 and a 58-step serial divide.
// The output register lets the next word be accepted while a result waits;
// when i_out_stall stays high, the next result waits in the sequencer and
// the input stalls. Reset loads the register defaults, sets the filtered
// level to mid scale, clears the counters and empties the output register.
// Configuration writes take effect with the next step that reads them.
module motor_speed_set_and_measure_unit import mssm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_func,
    input  logic [ADC_BITS-1:0]  i_sample,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [15:0]          o_compare_value,
    output logic [15:0]          o_expected_rpm,
    output logic [31:0]          o_measured_rpm,
    output logic                 o_measure_done
);

    // Control and configuration registers.
    t_state                r_state, n_state;
    logic [15:0]           r_min_duty, n_min_duty;
    logic [15:0]           r_period, n_period;
    logic [23:0]           r_window, n_window;
    logic [7:0]            r_ppr, n_ppr;
    logic [15:0]           r_full_rpm, n_full_rpm;
    logic [ADC_BITS-1:0]   r_level, n_level;
    logic [TALLY_W-1:0]    r_tally, n_tally;
    logic [23:0]           r_elapsed, n_elapsed;
    logic [31:0]           r_last_rpm, n_last_rpm;
    logic [15:0]           r_last_cmp, n_last_cmp;
    logic [15:0]           r_last_exp, n_last_exp;
    logic                  r_out_valid, n_out_valid;

    // Datapath registers.
    logic                  r_done, n_done;
    logic [PROD_W-1:0]     r_prod, n_prod;
    logic [16:0]           r_duty, n_duty;
    logic [33:0]           r_cmp_prod, n_cmp_prod;
    logic [NUM_W-1:0]      r_acc, n_acc;
    logic [NUM_W-1:0]      r_mcand, n_mcand;
    logic [MUL_W-1:0]      r_mplier, n_mplier;
    logic [DEN_W-1:0]      r_den, n_den;
    logic [15:0]           r_out_cmp, n_out_cmp;
    logic [15:0]           r_out_exp, n_out_exp;
    logic [31:0]           r_out_rpm, n_out_rpm;
    logic                  r_out_done, n_out_done;

    // Intermediate values.
    logic                  in_accept;
    logic                  slot_free;
    logic [ADC_BITS+2:0]   filt_sum;
    logic [23:0]           tick_next;
    logic [16:0]           duty_span;
    logic [SPAN_W-1:0]     lvl_span;
    logic [SPAN_W-1:0]     lvl_rpm;
    logic [17:0]           cmp_q;
    t_div_req              div_req;
    logic                  div_done;
    logic [NUM_W-1:0]      div_quo;

    mssm_sdiv u_sdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign o_in_stall      = (r_state != ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_compare_value = r_out_cmp;
    assign o_expected_rpm  = r_out_exp;
    assign o_measured_rpm  = r_out_rpm;
    assign o_measure_done  = r_out_done;

    // Arithmetic that feeds the sequencer.
    always_comb begin
        in_accept = i_in_valid && !o_in_stall;
        slot_free = !r_out_valid || !i_out_stall;
        filt_sum  = ({3'b000, r_level} << 3) - {3'b000, r_level} + {3'b000, i_sample};
        tick_next = r_elapsed + 24'd1;
        duty_span = ONE_Q16 - {1'b0, r_min_duty};
        lvl_span  = SPAN_W'(r_level) * SPAN_W'(duty_span);
        lvl_rpm   = SPAN_W'({r_level, 1'b0}) * SPAN_W'(r_full_rpm);
        cmp_q     = r_cmp_prod[33:16];
    end

    // Divider requests issued from the start states.
    always_comb begin
        div_req       = '0;
        div_req.num   = {r_prod, {(NUM_W-PROD_W){1'b0}}};
        div_req.steps = SAMPLE_STEPS;
        div_req.den   = DEN_W'(ADC_FULL);
        case (r_state)
            ST_DUTY_START: begin
                div_req.start = 1'b1;
            end
            ST_EXP_START: begin
                div_req.start = 1'b1;
                div_req.den   = DEN_W'(2 * ADC_FULL);
            end
            ST_TICK_START: begin
                div_req.start = (r_den != '0);
                div_req.num   = r_acc;
                div_req.steps = TICK_STEPS;
                div_req.den   = r_den;
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    // Next state and register updates.
    always_comb begin
        n_state     = r_state;
        n_min_duty  = r_min_duty;
        n_period    = r_period;
        n_window    = r_window;
        n_ppr       = r_ppr;
        n_full_rpm  = r_full_rpm;
        n_level     = r_level;
        n_tally     = r_tally;
        n_elapsed   = r_elapsed;
        n_last_rpm  = r_last_rpm;
        n_last_cmp  = r_last_cmp;
        n_last_exp  = r_last_exp;
        n_out_valid = r_out_valid && i_out_stall;
        n_done      = r_done;
        n_prod      = r_prod;
        n_duty      = r_duty;
        n_cmp_prod  = r_cmp_prod;
        n_acc       = r_acc;
        n_mcand     = r_mcand;
        n_mplier    = r_mplier;
        n_den       = r_den;
        n_out_cmp   = r_out_cmp;
        n_out_exp   = r_out_exp;
        n_out_rpm   = r_out_rpm;
        n_out_done  = r_out_done;

        // Register writes; unknown indexes are dropped.
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MIN_DUTY: n_min_duty = i_cfg_data[15:0];
                CFG_PERIOD:   n_period   = i_cfg_data[15:0];
                CFG_WINDOW:   n_window   = i_cfg_data[23:0];
                CFG_PPR:      n_ppr      = i_cfg_data[7:0];
                CFG_FULL_RPM: n_full_rpm = i_cfg_data[15:0];
                default:      n_ppr      = r_ppr;
            endcase
        end

        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_done  = 1'b0;
                    n_state = ST_WRITE;
                    case (t_func'(i_func))
                        FUNC_SAMPLE: begin
                            n_level = filt_sum[ADC_BITS+2:3];
                            n_state = ST_DUTY_MUL;
                        end
                        FUNC_PULSE: begin
                            if (r_tally != '1) begin
                                n_tally = r_tally + TALLY_W'(1);
                            end
                        end
                        FUNC_TICK: begin
                            n_elapsed = tick_next;
                            if (tick_next >= r_window) begin
                                n_state = ST_TICK_DEN;
                            end
                        end
                        default: begin
                            n_state = ST_WRITE;
                        end
                    endcase
                end
            end

            // Duty = minimum + level * (1 - minimum) / full scale.
            ST_DUTY_MUL: begin
                n_prod  = {1'b0, lvl_span};
                n_state = ST_DUTY_START;
            end
            ST_DUTY_START: begin
                n_state = ST_DUTY_WAIT;
            end
            ST_DUTY_WAIT: begin
                if (div_done) begin
                    n_duty  = {1'b0, r_min_duty} + div_quo[16:0];
                    n_state = ST_CMP_MUL;
                end
            end

            // Compare value, clamped to the period.
            ST_CMP_MUL: begin
                n_cmp_prod = 34'(r_duty) * 34'({1'b0, r_period} + 17'd1);
                n_state    = ST_CMP_CLAMP;
            end
            ST_CMP_CLAMP: begin
                if (cmp_q > {2'b00, r_period}) begin
                    n_last_cmp = r_period;
                end else begin
                    n_last_cmp = cmp_q[15:0];
                end
                n_prod  = {1'b0, lvl_rpm} + PROD_W'(ADC_FULL);
                n_state = ST_EXP_START;
            end

            // Expected speed, rounded half up.
            ST_EXP_START: begin
                n_state = ST_EXP_WAIT;
            end
            ST_EXP_WAIT: begin
                if (div_done) begin
                    if (div_quo[NUM_W-1:16] != '0) begin
                        n_last_exp = 16'hFFFF;
                    end else begin
                        n_last_exp = div_quo[15:0];
                    end
                    n_state = ST_WRITE;
                end
            end

            // Window closed: pulses * 60e6 / (ppr * elapsed).
            ST_TICK_DEN: begin
                n_den    = DEN_W'(r_ppr) * DEN_W'(r_elapsed);
                n_acc    = '0;
                n_mcand  = {{(NUM_W-TALLY_W){1'b0}}, r_tally};
                n_mplier = US_PER_MIN;
                n_state  = ST_TICK_MUL;
            end
            ST_TICK_MUL: begin
                if (r_mplier == '0) begin
                    n_state = ST_TICK_START;
                end else begin
                    if (r_mplier[0]) begin
                        n_acc = r_acc + r_mcand;
                    end
                    n_mcand  = {r_mcand[NUM_W-2:0], 1'b0};
                    n_mplier = {1'b0, r_mplier[MUL_W-1:1]};
                end
            end
            ST_TICK_START: begin
                if (r_den == '0) begin
                    n_last_rpm = '0;
                    n_tally    = '0;
                    n_elapsed  = '0;
                    n_done     = 1'b1;
                    n_state    = ST_WRITE;
                end else begin
                    n_state = ST_TICK_WAIT;
                end
            end
            ST_TICK_WAIT: begin
                if (div_done) begin
                    if (div_quo[NUM_W-1:32] != '0) begin
                        n_last_rpm = '1;
                    end else begin
                        n_last_rpm = div_quo[31:0];
                    end
                    n_tally   = '0;
                    n_elapsed = '0;
                    n_done    = 1'b1;
                    n_state   = ST_WRITE;
                end
            end

            // Hand the result word to the output register.
            ST_WRITE: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_cmp   = r_last_cmp;
                    n_out_exp   = r_last_exp;
                    n_out_rpm   = r_last_rpm;
                    n_out_done  = r_done;
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control and configuration state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_min_duty  <= MIN_DUTY_RESET;
            r_period    <= PERIOD_RESET;
            r_window    <= WINDOW_RESET;
            r_ppr       <= PPR_RESET;
            r_full_rpm  <= FULL_RPM_RESET;
            r_level     <= LEVEL_RESET;
            r_tally     <= '0;
            r_elapsed   <= '0;
            r_last_rpm  <= '0;
            r_last_cmp  <= '0;
            r_last_exp  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_min_duty  <= n_min_duty;
            r_period    <= n_period;
            r_window    <= n_window;
            r_ppr       <= n_ppr;
            r_full_rpm  <= n_full_rpm;
            r_level     <= n_level;
            r_tally     <= n_tally;
            r_elapsed   <= n_elapsed;
            r_last_rpm  <= n_last_rpm;
            r_last_cmp  <= n_last_cmp;
            r_last_exp  <= n_last_exp;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath and output word registers.
    always_ff @(posedge i_clk) begin
        r_done     <= n_done;
        r_prod     <= n_prod;
        r_duty     <= n_duty;
        r_cmp_prod <= n_cmp_prod;
        r_acc      <= n_acc;
        r_mcand    <= n_mcand;
        r_mplier   <= n_mplier;
        r_den      <= n_den;
        r_out_cmp  <= n_out_cmp;
        r_out_exp  <= n_out_exp;
        r_out_rpm  <= n_out_rpm;
        r_out_done <= n_out_done;
    end

endmodule

>>> verif/tb_motor_speed_set_and_measure_unit.sv
// Self-checking testbench for the motor speed set and measure unit.
module tb_motor_speed_set_and_measure_unit import mssm_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD      = 12;
    localparam int RESET_CYCLES    = 10;
    localparam int SETTLE_CYCLES   = 120;
    localparam int LIMIT_CYCLES    = 1_000_000;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 172;

    localparam logic [63:0] FULL_SCALE    = 64'((1 << ADC_BITS) - 1);
    localparam logic [63:0] Q16_UNITY     = 64'd65536;
    localparam logic [63:0] US_PER_MINUTE = 64'd60000000;
    localparam logic [TALLY_W-1:0] TALLY_TOP = '1;

    // Register indexes past the last register; writes to them are dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam logic [CFG_IDX_W-1:0] NO_INDEX     = '0;

    localparam logic ROW_ITEM      = 1'b0;
    localparam logic ROW_WRITE     = 1'b1;
    localparam logic ANS_PREDICTED = 1'b0;
    localparam logic ANS_TYPED     = 1'b1;

    typedef struct packed {
        logic [15:0] compare_value;
        logic [15:0] expected_rpm;
        logic [31:0] measured_rpm;
        logic        measure_done;
    } t_speed_word;

    typedef struct packed {
        logic        typed;
        t_speed_word want;
    } t_fixed_answer;

    typedef struct packed {
        logic                 is_write;
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_W-1:0]     data;
        t_func                func;
        logic [ADC_BITS-1:0]  sample;
        logic                 typed;
        t_speed_word          want;
    } t_plan_row;

    typedef enum int {
        SEQ_PULSES,
        SEQ_TICKS,
        SEQ_SAMPLES,
        SEQ_NOISE
    } t_seq_kind;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    localparam t_speed_word ZERO_WORD = '0;

    // Directed stimulus: reset values, extremes, masking of wide register data,
    // zero window, zero pulses per revolution, a window lowered mid-window,
    // the unused event code and writes to indexes past the last register.
    localparam int PLAN_ROWS = 42;
    t_plan_row plan [PLAN_ROWS] = '{
        '{ROW_ITEM,  NO_INDEX,     24'h000000, FUNC_PULSE,  12'h000, ANS_TYPED, ZERO_WORD},
        '{ROW_ITEM,  NO_INDEX,     24'h000000, FUNC_NONE,   12'hFFF, ANS_TYPED, ZERO_WORD},
        '{ROW_ITEM,  NO_INDEX,     24'h000000, FUNC_TICK,   12'h000, ANS_TYPED, ZERO_WORD},
        '{ROW_ITEM,  NO_INDEX,     24'h000000, FUNC_SAMPLE, 12'h000, ANS_PREDICTED, ZERO_WORD},
        '{ROW_ITEM,  NO_INDEX,     24'h000000, FUNC_SAMPLE, 12'hFFF, ANS_PREDICTED, ZERO_WORD},
        '{ROW_WRITE, CFG_MIN_DUTY, 24'hFFFFFF, FUNC_NONE,   12'h000, ANS_PREDICTED, ZERO_WORD},
        '{ROW_WRITE, CFG_PERIOD,   24'hFF0000, FUNC_NONE,   12'h000, ANS_PREDICTED, ZERO_WORD},
        '{ROW_WRITE, CFG_FULL_RPM, 24'h000000, FUNC_NONE,   12'h000, ANS_PREDICTED, ZERO_WORD},
        '{ROW_ITEM,  NO_INDEX,     24'h000000, FUNC_SAMPLE, 12'hFFF, ANS_TYPED, ZERO_WORD},
        '{ROW_WRITE, CFG_MIN_DUTY, 24'h000000, FUNC_NONE,   12'h000, ANS_PREDICTED, ZERO_WORD},
        '{ROW_WRITE, CFG_PERIOD,   24'h00FFFF, FUNC_NONE,   12'h000, ANS_PREDICTED, ZERO_WORD},
        '{ROW_WRITE, CFG_FULL_RPM, 24'h00FFFF, FUNC_NONE,   12'h000, ANS_PREDICTED, ZERO_WORD},
        '{ROW_ITEM,  NO_INDEX,     24'h000000, FUNC_SAMPLE, 12'hFFF, ANS_PREDICTED, ZERO_WORD},
        '{ROW_ITEM,  NO_INDEX,     24'h000000, FUNC_SAMPLE, 12'hFFF, ANS_PREDICTED, ZERO_WORD},
        '{ROW_ITEM,  NO_INDEX,     24'h000000, FUNC_SAMPLE, 12'h000, ANS_PREDICTED, ZERO_WORD},
        '{ROW_WRITE, CFG_WINDOW,   24'h000001, FUNC_NONE,   12'h000, ANS_PREDICTED, ZERO_WORD},
        '{ROW_WRITE, CFG_PPR,      24'h000001, FUNC_NONE,   12'h000, ANS_PREDICTED, ZERO_WORD},
        '{ROW_ITEM,  NO_INDEX,     24'h000000, FUNC_TICK,   12'h000, ANS_PREDICTED, ZERO_WORD},
        '{ROW_ITEM,  NO_INDEX,     24'h000000, FUNC_PULSE,  12'h555, ANS_PREDICTED, ZERO_WORD},
        '{ROW_ITEM,  NO_INDEX,     24'h000000, FUNC_PULSE,  12'hAAA, ANS_PREDICTED, ZERO_WORD},
        '{ROW_ITEM,  NO_INDEX,     24'h000000, FUNC_PULSE,  12'h000, ANS_PREDICTED, ZERO_WORD},
        '{ROW_ITEM,  NO_INDEX,     24'h000000, FUNC_TICK,   12'hFFF, ANS_PREDICTED, ZERO_WORD},
        '{ROW_WRITE, CFG_PPR,      24'hFFFF00, FUNC_NONE,   12'h000, ANS_PREDICTED, ZERO_WORD},
        '{ROW_ITEM,  NO_INDEX,     24'h000000, FUNC_PULSE,  12'h000, ANS_PREDICTED, ZERO_WORD},
        '{ROW_ITEM,  NO_INDEX,     24'h000000, FUNC_TICK,   12'h000, ANS_PREDICTED, ZERO_WORD},
        '{ROW_WRITE, CFG_WINDOW,   24'h000000, FUNC_NONE,   12'h000, ANS_PREDICTED, ZERO_WORD},
        '{ROW_WRITE, CFG_PPR,      24'h0000FF, FUNC_NONE,   12'h000, ANS_PREDICTED, ZERO_WORD},
        '{ROW_ITEM,  NO_INDEX,     24'h000000, FUNC_TICK,   12'h000, ANS_PREDICTED, ZERO_WORD},
        '{ROW_ITEM,  NO_INDEX,     24'h000000, FUNC_PULSE,  12'h000, ANS_PREDICTED, ZERO_WORD},
        '{ROW_ITEM,  NO_INDEX,     24'h000000, FUNC_TICK,   12'h000, ANS_PREDICTED, ZERO_WORD},
        '{ROW_WRITE, CFG_WINDOW,   24'h000064, FUNC_NONE,   12'h000, ANS_PREDICTED, ZERO_WORD},
        '{ROW_ITEM,  NO_INDEX,     24'h000000, FUNC_TICK,   12'h000, ANS_PREDICTED, ZERO_WORD},
        '{ROW_ITEM,  NO_INDEX,     24'h000000, FUNC_PULSE,  12'h000, ANS_PREDICTED, ZERO_WORD},
        '{ROW_ITEM,  NO_INDEX,     24'h000000, FUNC_TICK,   12'h000, ANS_PREDICTED, ZERO_WORD},
        '{ROW_ITEM,  NO_INDEX,     24'h000000, FUNC_PULSE,  12'h000, ANS_PREDICTED, ZERO_WORD},
        '{ROW_ITEM,  NO_INDEX,     24'h000000, FUNC_TICK,   12'h000, ANS_PREDICTED, ZERO_WORD},
        '{ROW_WRITE, CFG_WINDOW,   24'h000002, FUNC_NONE,   12'h000, ANS_PREDICTED, ZERO_WORD},
        '{ROW_ITEM,  NO_INDEX,     24'h000000, FUNC_TICK,   12'h000, ANS_PREDICTED, ZERO_WORD},
        '{ROW_WRITE, CFG_SPARE_LO, 24'hFFFFFF, FUNC_NONE,   12'h000, ANS_PREDICTED, ZERO_WORD},
        '{ROW_WRITE, CFG_SPARE_HI, 24'h000000, FUNC_NONE,   12'h000, ANS_PREDICTED, ZERO_WORD},
        '{ROW_ITEM,  NO_INDEX,     24'h000000, FUNC_SAMPLE, 12'h320, ANS_PREDICTED, ZERO_WORD},
        '{ROW_ITEM,  NO_INDEX,     24'h000000, FUNC_NONE,   12'h000, ANS_PREDICTED, ZERO_WORD}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [1:0]           i_func;
    logic [ADC_BITS-1:0]  i_sample;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [15:0]          o_compare_value;
    logic [15:0]          o_expected_rpm;
    logic [31:0]          o_measured_rpm;
    logic                 o_measure_done;

    // Expected output words, and typed answers queued alongside each sent word.
    t_speed_word   speed_word_q [$];
    t_fixed_answer fixed_q [$];

    int fail_count   = 0;
    int results_seen = 0;
    int cycle_count  = 0;
    int burst_left   = 0;

    // Predictor copy of the registers.
    logic [15:0] p_min_duty;
    logic [15:0] p_period;
    logic [23:0] p_window;
    logic [7:0]  p_ppr;
    logic [15:0] p_full_rpm;

    // Predictor copy of the block state.
    logic [ADC_BITS-1:0] p_level;
    logic [TALLY_W-1:0]  p_pulses;
    logic [23:0]         p_ticks;
    logic [31:0]         p_rpm_hold;
    logic [15:0]         p_cmp_hold;
    logic [15:0]         p_spd_hold;

    motor_speed_set_and_measure_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_func          (i_func),
        .i_sample        (i_sample),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_compare_value (o_compare_value),
        .o_expected_rpm  (o_expected_rpm),
        .o_measured_rpm  (o_measured_rpm),
        .o_measure_done  (o_measure_done)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Registers and state as they stand after reset.
    function automatic void reset_speed_state();
        p_min_duty = MIN_DUTY_RESET;
        p_period   = PERIOD_RESET;
        p_window   = WINDOW_RESET;
        p_ppr      = PPR_RESET;
        p_full_rpm = FULL_RPM_RESET;
        p_level    = LEVEL_RESET;
        p_pulses   = '0;
        p_ticks    = '0;
        p_rpm_hold = '0;
        p_cmp_hold = '0;
        p_spd_hold = '0;
    endfunction

    // Advance the predicted state by one event and return the output word.
    function automatic t_speed_word speed_after_event(input t_func f,
                                                      input logic [ADC_BITS-1:0] s);
        logic [63:0] avg, duty, cmp, spd, num, den, rpm;
        t_speed_word w;
        logic        closed;
        closed = 1'b0;
        case (f)
            FUNC_SAMPLE: begin
                avg     = (64'(p_level) * 64'd7 + 64'(s)) / 64'd8;
                p_level = avg[ADC_BITS-1:0];
                duty    = 64'(p_min_duty)
                        + (avg * (Q16_UNITY - 64'(p_min_duty))) / FULL_SCALE;
                cmp     = (duty * (64'(p_period) + 64'd1)) / Q16_UNITY;
                if (cmp > 64'(p_period)) begin
                    cmp = 64'(p_period);
                end
                p_cmp_hold = cmp[15:0];
                // Expected speed rounds half up.
                spd = (64'd2 * avg * 64'(p_full_rpm) + FULL_SCALE) / (64'd2 * FULL_SCALE);
                if (spd > 64'hFFFF) begin
                    spd = 64'hFFFF;
                end
                p_spd_hold = spd[15:0];
            end
            FUNC_PULSE: begin
                if (p_pulses != TALLY_TOP) begin
                    p_pulses = p_pulses + TALLY_W'(1);
                end
            end
            FUNC_TICK: begin
                p_ticks = p_ticks + 24'd1;
                // A zero window closes on every tick; the divide uses the
                // elapsed count in case the window was lowered mid-window.
                if (p_ticks >= p_window) begin
                    den = 64'(p_ppr) * 64'(p_ticks);
                    if (den == 64'd0) begin
                        rpm = 64'd0;
                    end else begin
                        num = 64'(p_pulses) * US_PER_MINUTE;
                        rpm = num / den;
                        if (rpm > 64'hFFFF_FFFF) begin
                            rpm = 64'hFFFF_FFFF;
                        end
                    end
                    p_rpm_hold = rpm[31:0];
                    p_pulses   = '0;
                    p_ticks    = '0;
                    closed     = 1'b1;
                end
            end
            default: begin
            end
        endcase
        w.compare_value = p_cmp_hold;
        w.expected_rpm  = p_spd_hold;
        w.measured_rpm  = p_rpm_hold;
        w.measure_done  = closed;
        return w;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_count++;
        $display("[%0t] mismatch in %s at result %0d: got %0h, want %0h",
                 $time, what, results_seen, got, want);
    endtask

    // Track register writes, predict accepted words and check output words.
    always @(posedge i_clk) begin : scoreboard
        t_fixed_answer fa;
        t_speed_word   predicted;
        t_speed_word   want;
        if (!i_rst_n) begin
            reset_speed_state();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MIN_DUTY: p_min_duty = i_cfg_data[15:0];
                    CFG_PERIOD:   p_period   = i_cfg_data[15:0];
                    CFG_WINDOW:   p_window   = i_cfg_data[23:0];
                    CFG_PPR:      p_ppr      = i_cfg_data[7:0];
                    CFG_FULL_RPM: p_full_rpm = i_cfg_data[15:0];
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                fa        = fixed_q.pop_front();
                predicted = speed_after_event(t_func'(i_func), i_sample);
                speed_word_q.push_back(fa.typed ? fa.want : predicted);
            end
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (speed_word_q.size() == 0) begin
                    report_mismatch("word with nothing expected", o_measured_rpm, 32'd0);
                end else begin
                    want = speed_word_q.pop_front();
                    if (o_compare_value !== want.compare_value) begin
                        report_mismatch("compare_value", 32'(o_compare_value),
                                        32'(want.compare_value));
                    end
                    if (o_expected_rpm !== want.expected_rpm) begin
                        report_mismatch("expected_rpm", 32'(o_expected_rpm),
                                        32'(want.expected_rpm));
                    end
                    if (o_measured_rpm !== want.measured_rpm) begin
                        report_mismatch("measured_rpm", o_measured_rpm, want.measured_rpm);
                    end
                    if (o_measure_done !== want.measure_done) begin
                        report_mismatch("measure_done", 32'(o_measure_done),
                                        32'(want.measure_done));
                    end
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("motor_speed_set_and_measure_unit regression: fail");
            $finish;
        end
    end

    // Output stall: stretches of no stall, light and heavy random stall, and a
    // periodic on/off pattern.
    initial begin : out_stall_pattern
        t_stall_mode mode;
        int          span, on_len, off_len, k;
        i_out_stall <= 1'b0;
        forever begin
            mode    = t_stall_mode'($urandom_range(0, 3));
            span    = $urandom_range(20, 400);
            on_len  = $urandom_range(1, 40);
            off_len = $urandom_range(1, 12);
            for (k = 0; k < span; k++) begin
                @(posedge i_clk);
                case (mode)
                    STALL_NONE:  i_out_stall <= 1'b0;
                    STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
                    default:     i_out_stall <= ((k % (on_len + off_len)) < on_len);
                endcase
            end
        end
    end

    // Send one input word; bursts of random length with random gaps between.
    task automatic send_word(input t_func f, input logic [ADC_BITS-1:0] s,
                             input logic typed, input t_speed_word want);
        t_fixed_answer fa;
        int            gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 16);
            if ($urandom_range(0, 2) != 0) begin
                gap = $urandom_range(1, 20);
            end
        end
        burst_left--;
        fa.typed = typed;
        fa.want  = want;
        fixed_q.push_back(fa);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= f;
        i_sample   <= s;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Stop sending, wait for every expected word, then let the block settle.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (speed_word_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin : stimulus
        t_seq_kind           kind;
        int                  phase, n, len, r;
        logic                items_pending;
        logic [15:0]         min_v, period_v, full_v;
        logic [23:0]         win_v;
        logic [7:0]          ppr_v;
        logic [ADC_BITS-1:0] s;

        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_func      <= '0;
        i_sample    <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table; registers change only once the block is idle.
        items_pending = 1'b0;
        for (r = 0; r < PLAN_ROWS; r++) begin
            if (plan[r].is_write) begin
                if (items_pending) begin
                    drain_results();
                    items_pending = 1'b0;
                end
                write_reg(plan[r].index, plan[r].data);
            end else begin
                send_word(plan[r].func, plan[r].sample, plan[r].typed, plan[r].want);
                items_pending = 1'b1;
            end
        end

        // Random phases, each with its own register setting.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_results();
            min_v    = 16'($urandom);
            period_v = 16'($urandom);
            win_v    = 24'($urandom_range(1, 40));
            ppr_v    = 8'($urandom_range(1, 255));
            full_v   = 16'($urandom);
            case (phase)
                0: begin
                    min_v    = 16'h0000;
                    period_v = 16'hFFFF;
                    win_v    = 24'd1;
                    ppr_v    = 8'd1;
                    full_v   = 16'hFFFF;
                end
                1: begin
                    min_v    = 16'hFFFF;
                    period_v = 16'h0000;
                    win_v    = 24'd0;
                    ppr_v    = 8'hFF;
                    full_v   = 16'h0000;
                end
                2: ppr_v    = 8'd0;
                3: win_v    = 24'hFFFFFF;
                4: period_v = 16'($urandom_range(0, 20));
                default: begin
                end
            endcase
            write_reg(CFG_MIN_DUTY, {8'($urandom), min_v});
            write_reg(CFG_PERIOD,   {8'($urandom), period_v});
            write_reg(CFG_WINDOW,   win_v);
            write_reg(CFG_PPR,      {16'($urandom), ppr_v});
            write_reg(CFG_FULL_RPM, {8'($urandom), full_v});
            write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)),
                      CFG_W'($urandom));

            // Mostly pulse trains, tick trains and sample runs, some noise.
            n = 0;
            while (n < ITEMS_PER_PHASE) begin
                r = $urandom_range(0, 9);
                kind = (r < 4) ? SEQ_PULSES : (r < 7) ? SEQ_TICKS
                     : (r < 9) ? SEQ_SAMPLES : SEQ_NOISE;
                case (kind)
                    SEQ_PULSES: begin
                        // Long trains in the first phase push the speed into saturation.
                        len = (phase == 0) ? $urandom_range(1, 150) : $urandom_range(1, 20);
                        repeat (len) send_word(FUNC_PULSE, ADC_BITS'($urandom),
                                               ANS_PREDICTED, ZERO_WORD);
                    end
                    SEQ_TICKS: begin
                        len = $urandom_range(1, 12);
                        repeat (len) send_word(FUNC_TICK, ADC_BITS'($urandom),
                                               ANS_PREDICTED, ZERO_WORD);
                    end
                    SEQ_SAMPLES: begin
                        len = $urandom_range(1, 5);
                        repeat (len) begin
                            case ($urandom_range(0, 7))
                                0:       s = '0;
                                1:       s = '1;
                                default: s = ADC_BITS'($urandom);
                            endcase
                            send_word(FUNC_SAMPLE, s, ANS_PREDICTED, ZERO_WORD);
                        end
                    end
                    default: begin
                        len = 1;
                        send_word(t_func'($urandom_range(0, 3)), ADC_BITS'($urandom),
                                  ANS_PREDICTED, ZERO_WORD);
                    end
                endcase
                n += len;
            end
        end

        drain_results();
        if (fail_count == 0) begin
            $display("motor_speed_set_and_measure_unit regression: pass");
        end else begin
            $display("motor_speed_set_and_measure_unit regression: fail");
        end
        $finish;
    end

endmodule
